// File: sv/dlss_pkg.sv
// Shared types, codes and defaults of the digital line strip scanner.
package dlss_pkg;

    localparam int PATTERN_MAX_DEF = 64;
    localparam int MAX_SCAN_DEF    = 64;
    localparam int COORD_BITS_DEF  = 16;
    localparam int ADDR_W          = 6;
    localparam int DATA_W          = 64;

    typedef enum logic [1:0] {
        CMD_FIRST  = 2'd0,
        CMD_LEFT   = 2'd1,
        CMD_RIGHT  = 2'd2,
        CMD_LOCATE = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        REG_LINE_A         = 3'd0,
        REG_LINE_B         = 3'd1,
        REG_UPPER_BOUND    = 3'd2,
        REG_WINDOW_BOUNDS  = 3'd3,
        REG_STEP_PATTERN   = 3'd4,
        REG_PATTERN_LENGTH = 3'd5,
        REG_START_POINT    = 3'd6
    } t_reg_idx;

    typedef enum logic [3:0] {
        ST_IDLE, ST_WALK, ST_LOAD, ST_MUL, ST_SUM, ST_SKIP, ST_COUNT,
        ST_REWIND, ST_EMIT, ST_LOCA, ST_LOCB, ST_LOCOUT
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE, OP_WALK, OP_LOAD, OP_MUL, OP_SUM, OP_SKIP_STEP, OP_SAVE,
        OP_COUNT_STEP, OP_CUT, OP_REWIND, OP_EMIT, OP_LOCA_STEP,
        OP_LOCB_INIT, OP_LOCB_STEP, OP_LOC_OUT
    } t_dp_op;

    typedef struct packed {
        logic signed [15:0] line_a;
        logic signed [15:0] line_b;
        logic signed [31:0] upper_bound;
        logic [63:0]        window_bounds;
        logic [63:0]        step_pattern;
        logic [6:0]         pattern_length;
        logic [31:0]        start_point;
    } t_cfg;

    typedef struct packed {
        logic walk_init;
        logic start_load;
    } t_cfg_evt;

    typedef struct packed {
        logic   capture;
        t_dp_op op;
    } t_dp_ctl;

    typedef struct packed {
        t_cmd cmd;
        logic skip_go;
        logic in_go;
        logic cnt_full;
        logic last_emit;
        logic loca_go;
        logic locb_go;
    } t_dp_sts;

    typedef struct packed {
        logic signed [15:0] point_x;
        logic signed [15:0] point_y;
        logic signed [15:0] scan_index;
        logic signed [15:0] along_position;
        logic               last;
        logic               empty_res;
        logic               truncated;
    } t_res;

endpackage

// File: sv/dlss_if.sv
// Request and result channel interfaces of the scanner.
interface dlss_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         command;
    logic signed [15:0] query_x;
    logic signed [15:0] query_y;

    modport source (output valid, command, query_x, query_y, input ready);
    modport sink   (input valid, command, query_x, query_y, output ready);
endinterface

interface dlss_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic signed [15:0] scan_index;
    logic signed [15:0] along_position;
    logic               last;
    logic               empty_res;
    logic               truncated;

    modport source (output valid, point_x, point_y, scan_index, along_position, last,
                    empty_res, truncated, input ready);
    modport sink   (input valid, point_x, point_y, scan_index, along_position, last,
                    empty_res, truncated, output ready);
endinterface

// File: sv/dlss_regs.sv
// APB configuration register file of the scanner.
module dlss_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [dlss_pkg::ADDR_W-1:0] paddr,
    input  logic [dlss_pkg::DATA_W-1:0] pwdata,
    output logic [dlss_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output dlss_pkg::t_cfg             o_cfg,
    output dlss_pkg::t_cfg_evt         o_evt
);
    import dlss_pkg::*;

    t_cfg     r_cfg;
    t_cfg_evt r_evt;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[ADDR_W-1:3]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;
    assign o_evt  = r_evt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg                <= '0;
            r_cfg.pattern_length <= 7'd1;
            r_evt                <= '0;
        end else begin
            r_evt <= '0;
            if (w_wr) begin
                case (w_idx)
                    REG_LINE_A:         r_cfg.line_a <= pwdata[15:0];
                    REG_LINE_B:         r_cfg.line_b <= pwdata[15:0];
                    REG_UPPER_BOUND:    r_cfg.upper_bound <= pwdata[31:0];
                    REG_WINDOW_BOUNDS:  r_cfg.window_bounds <= pwdata;
                    REG_STEP_PATTERN:   r_cfg.step_pattern <= pwdata;
                    REG_PATTERN_LENGTH: begin
                        r_cfg.pattern_length <= pwdata[6:0];
                        r_evt.walk_init      <= 1'b1;
                    end
                    REG_START_POINT: begin
                        r_cfg.start_point <= pwdata[31:0];
                        r_evt.start_load  <= 1'b1;
                    end
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        case (w_idx)
            REG_LINE_A:         prdata = DATA_W'(unsigned'(r_cfg.line_a));
            REG_LINE_B:         prdata = DATA_W'(unsigned'(r_cfg.line_b));
            REG_UPPER_BOUND:    prdata = DATA_W'(unsigned'(r_cfg.upper_bound));
            REG_WINDOW_BOUNDS:  prdata = r_cfg.window_bounds;
            REG_STEP_PATTERN:   prdata = r_cfg.step_pattern;
            REG_PATTERN_LENGTH: prdata = DATA_W'(r_cfg.pattern_length);
            REG_START_POINT:    prdata = DATA_W'(r_cfg.start_point);
            default:            prdata = '0;
        endcase
    end
endmodule

// File: sv/dlss_ctrl.sv
// Sequencing state machine of the scanner.
module dlss_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [1:0]        i_in_cmd,
    input  logic              i_out_ready,
    input  dlss_pkg::t_dp_sts i_sts,
    output logic              o_in_ready,
    output logic              o_out_valid,
    output dlss_pkg::t_dp_ctl o_ctl
);
    import dlss_pkg::*;

    t_state r_state, n_state;
    logic   r_ovalid, n_ovalid;
    logic   w_free;
    t_cmd   w_cmd;

    assign w_free      = !r_ovalid || i_out_ready;
    assign w_cmd       = t_cmd'(i_in_cmd);
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = (w_cmd == CMD_LEFT || w_cmd == CMD_RIGHT) ? ST_WALK : ST_LOAD;
                end
            end
            ST_WALK:   n_state = ST_LOAD;
            ST_LOAD:   n_state = (i_sts.cmd == CMD_LOCATE) ? ST_LOCA : ST_MUL;
            ST_MUL:    n_state = ST_SUM;
            ST_SUM:    n_state = ST_SKIP;
            ST_SKIP:   if (!i_sts.skip_go) n_state = ST_COUNT;
            ST_COUNT:  if (!i_sts.in_go || i_sts.cnt_full) n_state = ST_REWIND;
            ST_REWIND: n_state = ST_EMIT;
            ST_EMIT:   if (w_free && i_sts.last_emit) n_state = ST_IDLE;
            ST_LOCA:   if (!i_sts.loca_go) n_state = ST_LOCB;
            ST_LOCB:   if (!i_sts.locb_go) n_state = ST_LOCOUT;
            ST_LOCOUT: if (w_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ctl.capture = (r_state == ST_IDLE) && i_in_valid;
        o_ctl.op      = OP_NONE;
        case (r_state)
            ST_WALK:   o_ctl.op = OP_WALK;
            ST_LOAD:   o_ctl.op = OP_LOAD;
            ST_MUL:    o_ctl.op = OP_MUL;
            ST_SUM:    o_ctl.op = OP_SUM;
            ST_SKIP:   o_ctl.op = i_sts.skip_go ? OP_SKIP_STEP : OP_SAVE;
            ST_COUNT: begin
                if (i_sts.in_go) o_ctl.op = i_sts.cnt_full ? OP_CUT : OP_COUNT_STEP;
            end
            ST_REWIND: o_ctl.op = OP_REWIND;
            ST_EMIT:   if (w_free) o_ctl.op = OP_EMIT;
            ST_LOCA:   o_ctl.op = i_sts.loca_go ? OP_LOCA_STEP : OP_LOCB_INIT;
            ST_LOCB:   if (i_sts.locb_go) o_ctl.op = OP_LOCB_STEP;
            ST_LOCOUT: if (w_free) o_ctl.op = OP_LOC_OUT;
            default:   o_ctl.op = OP_NONE;
        endcase
        n_ovalid = (o_ctl.op == OP_EMIT || o_ctl.op == OP_LOC_OUT) ? 1'b1 :
                   (i_out_ready ? 1'b0 : r_ovalid);
    end
endmodule

// File: sv/dlss_dp.sv
// Datapath of the scanner: start point walkers, scan walker and locate unit.
module dlss_dp #(
    parameter int PATTERN_MAX = dlss_pkg::PATTERN_MAX_DEF,
    parameter int MAX_SCAN    = dlss_pkg::MAX_SCAN_DEF,
    parameter int COORD_BITS  = dlss_pkg::COORD_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dlss_pkg::t_cfg     i_cfg,
    input  dlss_pkg::t_cfg_evt i_evt,
    input  dlss_pkg::t_dp_ctl  i_ctl,
    input  logic [1:0]         i_cmd,
    input  logic signed [15:0] i_qx,
    input  logic signed [15:0] i_qy,
    output dlss_pkg::t_dp_sts  o_sts,
    output dlss_pkg::t_res     o_res
);
    import dlss_pkg::*;

    localparam int XW  = ((COORD_BITS > 16) ? COORD_BITS : 16) + 3;
    localparam int YW  = XW + 1;
    localparam int SW  = XW + 16;
    localparam int IW  = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int PLW = $clog2(PATTERN_MAX + 1);
    localparam int NW  = $clog2(MAX_SCAN + 1);

    logic [PLW-1:0] w_plen;

    function automatic logic [IW-1:0] f_inc(input logic [IW-1:0] i, input logic [PLW-1:0] p);
        logic [PLW:0] nx;
        nx = (PLW+1)'(i) + 1'b1;
        return (nx >= (PLW+1)'(p)) ? '0 : IW'(nx);
    endfunction

    function automatic logic [IW-1:0] f_dec(input logic [IW-1:0] i, input logic [PLW-1:0] p);
        logic [PLW-1:0] pm;
        pm = p - 1'b1;
        return (i == '0 || (PLW+1)'(i) >= (PLW+1)'(p)) ? IW'(pm) : i - 1'b1;
    endfunction

    always_comb begin
        if (i_cfg.pattern_length == 7'd0) begin
            w_plen = PLW'(1);
        end else if (i_cfg.pattern_length > 7'(PATTERN_MAX)) begin
            w_plen = PLW'(PATTERN_MAX);
        end else begin
            w_plen = i_cfg.pattern_length[PLW-1:0];
        end
    end

    // start point walker state
    logic signed [COORD_BITS-1:0] r_lx, r_ly, r_rx, r_ry, r_cx, r_cy;
    logic [IW-1:0]                r_lo, r_li, r_ro, r_ri;
    logic                         r_ltr, r_rtr;

    // scan and locate state
    t_cmd                r_cmd;
    logic signed [15:0]  r_px, r_py;
    logic signed [XW-1:0] r_x, r_y, r_x0, r_y0;
    logic signed [SW-1:0] r_s, r_pa, r_pb;
    logic [IW-1:0]       r_idx, r_idx0, r_s1, r_s2;
    logic [NW-1:0]       r_n, r_k;
    logic                r_cut, r_fwd, r_tr;
    logic signed [YW-1:0] r_ci, r_ny;
    t_res                r_res;

    logic signed [XW-1:0] w_xmin, w_ymin, w_xmax, w_ymax, w_pxe, w_cxe, w_cye;
    logic signed [SW-1:0] w_a, w_b, w_ub;
    logic                 w_pat, w_in;
    logic [IW-1:0]        w_lo_n, w_li_d, w_idx_d, w_s1_d, w_s2_d;

    assign w_xmin = XW'($signed(i_cfg.window_bounds[15:0]));
    assign w_ymin = XW'($signed(i_cfg.window_bounds[31:16]));
    assign w_xmax = XW'($signed(i_cfg.window_bounds[47:32]));
    assign w_ymax = XW'($signed(i_cfg.window_bounds[63:48]));
    assign w_a    = SW'($signed(i_cfg.line_a));
    assign w_b    = SW'($signed(i_cfg.line_b));
    assign w_ub   = SW'($signed(i_cfg.upper_bound));
    assign w_pxe  = XW'(r_px);
    assign w_cxe  = XW'(r_cx);
    assign w_cye  = XW'(r_cy);

    assign w_pat   = i_cfg.step_pattern[r_idx];
    assign w_in    = (r_s <= w_ub);
    assign w_lo_n  = f_dec(r_lo, w_plen);
    assign w_li_d  = f_dec(r_li, w_plen);
    assign w_idx_d = f_dec(r_idx, w_plen);
    assign w_s1_d  = f_dec(r_s1, w_plen);
    assign w_s2_d  = f_dec(r_s2, w_plen);

    always_comb begin
        o_sts.cmd       = r_cmd;
        o_sts.skip_go   = (r_y < w_ymin || r_x < w_xmin) && w_in && (r_x < w_xmax);
        o_sts.in_go     = w_in && (r_y < w_ymax) && (r_x < w_xmax);
        o_sts.cnt_full  = (r_n == NW'(MAX_SCAN));
        o_sts.last_emit = (r_n == '0) || ((r_k + 1'b1) == r_n);
        o_sts.loca_go   = r_fwd ? (r_x < w_pxe) : (r_x > w_pxe);
        o_sts.locb_go   = (r_ny != '0);
    end

    assign o_res = r_res;

    // start points: reloaded by configuration, advanced by next-left / next-right
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lx <= '0; r_ly <= '0; r_rx <= '0; r_ry <= '0; r_cx <= '0; r_cy <= '0;
            r_lo <= '0; r_li <= '0; r_ro <= '0; r_ri <= '0;
            r_ltr <= 1'b0; r_rtr <= 1'b0;
        end else if (i_evt.start_load || i_evt.walk_init) begin
            r_lo <= '0; r_li <= '0; r_ro <= '0; r_ri <= '0;
            r_ltr <= 1'b0; r_rtr <= 1'b0;
            if (i_evt.start_load) begin
                r_cx <= COORD_BITS'($signed(i_cfg.start_point[15:0]));
                r_cy <= COORD_BITS'($signed(i_cfg.start_point[31:16]));
                r_lx <= COORD_BITS'($signed(i_cfg.start_point[15:0]));
                r_ly <= COORD_BITS'($signed(i_cfg.start_point[31:16]));
                r_rx <= COORD_BITS'($signed(i_cfg.start_point[15:0]));
                r_ry <= COORD_BITS'($signed(i_cfg.start_point[31:16]));
            end
        end else if (i_ctl.op == OP_WALK) begin
            if (r_cmd == CMD_LEFT) begin
                if (r_ltr) begin
                    r_lx  <= r_lx - 1'b1;
                    r_li  <= w_li_d;
                    r_ltr <= 1'b0;
                end else begin
                    r_lo <= w_lo_n;
                    r_ly <= r_ly + 1'b1;
                    if (i_cfg.step_pattern[w_lo_n]) begin
                        if (i_cfg.step_pattern[w_li_d]) begin
                            r_ltr <= 1'b1;
                        end else begin
                            r_li <= w_li_d;
                            r_lx <= r_lx - 1'b1;
                        end
                    end
                end
            end else begin
                if (r_rtr) begin
                    r_ry  <= r_ry - 1'b1;
                    r_rtr <= 1'b0;
                end else begin
                    if (i_cfg.step_pattern[r_ro]) begin
                        r_rx <= r_rx + 1'b1;
                        // a set inner bit cancels the y step and enters transition
                        if (i_cfg.step_pattern[r_ri]) begin
                            r_rtr <= 1'b1;
                        end else begin
                            r_ry <= r_ry - 1'b1;
                        end
                        r_ri <= f_inc(r_ri, w_plen);
                    end else begin
                        r_ry <= r_ry - 1'b1;
                    end
                    r_ro <= f_inc(r_ro, w_plen);
                end
            end
        end
    end

    // request capture and the scan / locate walker
    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_cmd <= t_cmd'(i_cmd);
            r_px  <= i_qx;
            r_py  <= i_qy;
        end
        case (i_ctl.op)
            OP_LOAD: begin
                case (r_cmd)
                    CMD_LEFT: begin
                        r_x <= XW'(r_lx); r_y <= XW'(r_ly); r_idx <= r_li;
                    end
                    CMD_RIGHT: begin
                        r_x <= XW'(r_rx); r_y <= XW'(r_ry); r_idx <= r_ri;
                    end
                    default: begin
                        r_x <= w_cxe; r_y <= w_cye; r_idx <= '0;
                    end
                endcase
                r_fwd <= (w_pxe >= w_cxe);
            end
            OP_MUL: begin
                r_pa <= w_a * r_x;
                r_pb <= w_b * r_y;
            end
            OP_SUM: r_s <= r_pa + r_pb;
            OP_SKIP_STEP, OP_COUNT_STEP: begin
                r_x   <= r_x + 1'b1;
                r_y   <= r_y + XW'(w_pat);
                r_s   <= r_s + w_a + (w_pat ? w_b : '0);
                r_idx <= f_inc(r_idx, w_plen);
                if (i_ctl.op == OP_COUNT_STEP) r_n <= r_n + 1'b1;
            end
            OP_SAVE: begin
                r_x0   <= r_x;
                r_y0   <= r_y;
                r_idx0 <= r_idx;
                r_n    <= '0;
                r_cut  <= 1'b0;
            end
            OP_CUT: r_cut <= 1'b1;
            OP_REWIND: begin
                r_x   <= r_x0;
                r_y   <= r_y0;
                r_idx <= r_idx0;
                r_k   <= '0;
            end
            OP_EMIT: begin
                r_x   <= r_x + 1'b1;
                r_y   <= r_y + XW'(w_pat);
                r_idx <= f_inc(r_idx, w_plen);
                r_k   <= r_k + 1'b1;
            end
            OP_LOCA_STEP: begin
                if (r_fwd) begin
                    r_x   <= r_x + 1'b1;
                    r_y   <= r_y + XW'(w_pat);
                    r_idx <= f_inc(r_idx, w_plen);
                end else begin
                    r_x   <= r_x - 1'b1;
                    r_idx <= w_idx_d;
                    r_y   <= r_y - XW'(i_cfg.step_pattern[w_idx_d]);
                end
            end
            OP_LOCB_INIT: begin
                r_ci <= YW'(r_y) - YW'(r_py);
                r_ny <= YW'(r_y) - YW'(r_py);
                r_x  <= w_cxe;
                r_y  <= w_cye;
                r_s1 <= '0;
                r_s2 <= '0;
                r_tr <= 1'b0;
            end
            OP_LOCB_STEP: begin
                if (r_ci[YW-1]) begin
                    if (r_tr) begin
                        r_y  <= r_y - 1'b1;
                        r_tr <= 1'b0;
                    end else begin
                        r_s1 <= w_s1_d;
                        if (i_cfg.step_pattern[w_s1_d]) begin
                            r_x <= r_x - 1'b1;
                            if (i_cfg.step_pattern[r_s2]) begin
                                r_tr <= 1'b1;
                            end else begin
                                r_y <= r_y - 1'b1;
                            end
                            r_s2 <= f_inc(r_s2, w_plen);
                        end else begin
                            r_y <= r_y - 1'b1;
                        end
                    end
                    r_ny <= r_ny + 1'b1;
                end else begin
                    if (r_tr) begin
                        r_x  <= r_x + 1'b1;
                        r_s2 <= w_s2_d;
                        r_tr <= 1'b0;
                    end else begin
                        r_y <= r_y + 1'b1;
                        if (i_cfg.step_pattern[r_s1]) begin
                            if (i_cfg.step_pattern[w_s2_d]) begin
                                r_tr <= 1'b1;
                            end else begin
                                r_s2 <= w_s2_d;
                                r_x  <= r_x + 1'b1;
                            end
                        end
                        r_s1 <= f_inc(r_s1, w_plen);
                    end
                    r_ny <= r_ny - 1'b1;
                end
            end
            default: ;
        endcase

        if (i_ctl.op == OP_EMIT) begin
            r_res.point_x        <= (r_n == '0) ? '0 : r_x[15:0];
            r_res.point_y        <= (r_n == '0) ? '0 : r_y[15:0];
            r_res.scan_index     <= '0;
            r_res.along_position <= '0;
            r_res.last           <= o_sts.last_emit;
            r_res.empty_res      <= (r_n == '0);
            r_res.truncated      <= r_cut && (r_n != '0);
        end else if (i_ctl.op == OP_LOC_OUT) begin
            r_res.point_x        <= '0;
            r_res.point_y        <= '0;
            r_res.scan_index     <= r_ci[15:0];
            r_res.along_position <= r_px - r_x[15:0];
            r_res.last           <= 1'b1;
            r_res.empty_res      <= 1'b0;
            r_res.truncated      <= 1'b0;
        end
    end
endmodule

// File: sv/digital_line_strip_scanner.sv
// Top level of the digital line strip scanner.
// Scans parallel lines of a digital strip a*x + b*y <= bound in one octant.
// Request channel i_req carries a command (first scan, next left, next right,
// locate) and a query pixel; result channel o_res returns one or more results
// per request, the final one marked last. Registers are written over the APB
// port (8-byte stride); the user must write them only while no request is in
// flight, and the block itself does not enforce it. A scan request runs the
// setup steps walk, load, multiply and sum (a first scan has no walk), skips
// pixels outside the window one per cycle, counts pixels one per cycle up to
// MAX_SCAN, rewinds, then emits one point per cycle while the receiver is ready.
// The counting pass sets the truncated flag before the first point goes out.
// A locate request walks the scan to query_x, then walks the start point to the query's scan.
// One request is in work at a time; i_req.ready is high in idle, also while
// the last result still waits in the output register.
// A stalled receiver holds the output register and pauses the walker.
// Reset clears the registers (pattern length to 1), start points and walk indices and drops valid.
module digital_line_strip_scanner #(
    parameter int PATTERN_MAX = dlss_pkg::PATTERN_MAX_DEF,
    parameter int MAX_SCAN    = dlss_pkg::MAX_SCAN_DEF,
    parameter int COORD_BITS  = dlss_pkg::COORD_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    dlss_in_if.sink                     i_req,
    dlss_out_if.source                  o_res,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dlss_pkg::ADDR_W-1:0] paddr,
    input  logic [dlss_pkg::DATA_W-1:0] pwdata,
    output logic [dlss_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);
    import dlss_pkg::*;

    t_cfg     w_cfg;
    t_cfg_evt w_evt;
    t_dp_ctl  w_ctl;
    t_dp_sts  w_sts;
    t_res     w_res;

    dlss_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg),
        .o_evt   (w_evt)
    );

    dlss_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_in_cmd    (i_req.command),
        .i_out_ready (o_res.ready),
        .i_sts       (w_sts),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_res.valid),
        .o_ctl       (w_ctl)
    );

    dlss_dp #(
        .PATTERN_MAX (PATTERN_MAX),
        .MAX_SCAN    (MAX_SCAN),
        .COORD_BITS  (COORD_BITS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_evt   (w_evt),
        .i_ctl   (w_ctl),
        .i_cmd   (i_req.command),
        .i_qx    (i_req.query_x),
        .i_qy    (i_req.query_y),
        .o_sts   (w_sts),
        .o_res   (w_res)
    );

    assign o_res.point_x        = w_res.point_x;
    assign o_res.point_y        = w_res.point_y;
    assign o_res.scan_index     = w_res.scan_index;
    assign o_res.along_position = w_res.along_position;
    assign o_res.last           = w_res.last;
    assign o_res.empty_res      = w_res.empty_res;
    assign o_res.truncated      = w_res.truncated;
endmodule

// File: sv/dlss_checker.sv
// Port-level checks of the scanner, bound to the top level.
module dlss_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic signed [15:0] i_point_x,
    input logic signed [15:0] i_point_y,
    input logic signed [15:0] i_scan_index,
    input logic               i_last,
    input logic               i_empty_res,
    input logic               i_truncated
);
    a_no_valid_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid) else $error("result valid after reset");

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_empty_res |-> i_last && !i_truncated)
        else $error("empty result not last or marked truncated");

    a_empty_no_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_empty_res |-> i_point_x == 16'sd0 && i_point_y == 16'sd0)
        else $error("empty result carries a point");

    a_locate_no_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_scan_index != 16'sd0 |-> i_point_x == 16'sd0 && i_last)
        else $error("locate result carries a point or is not last");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_point_x))
        else $error("stalled result changed");
endmodule

bind digital_line_strip_scanner dlss_checker u_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_point_x    (o_res.point_x),
    .i_point_y    (o_res.point_y),
    .i_scan_index (o_res.scan_index),
    .i_last       (o_res.last),
    .i_empty_res  (o_res.empty_res),
    .i_truncated  (o_res.truncated)
);
